// ===== src/erx_pkg.sv =====
// shared types and constants of the escaped frame receiver
package erx_pkg;

   // field widths fixed by the frame format
   localparam int BYTE_W  = 8;
   localparam int TYPE_W  = 16;
   localparam int LEN_W   = 7;
   localparam int INDEX_W = 6;
   localparam int CSR_W   = 2;

   // escaped bytes are taken xor this mask
   localparam logic [BYTE_W-1:0] ESC_MASK = 8'h10;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_MAX_LENGTH  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_START_CHAR  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ESCAPE_CHAR = 2'd2;
   localparam logic [CSR_W-1:0] CSR_END_CHAR    = 2'd3;

   // configuration register reset values
   localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 7'd64;
   localparam logic [BYTE_W-1:0] START_CHAR_RST  = 8'd1;
   localparam logic [BYTE_W-1:0] ESCAPE_CHAR_RST = 8'd2;
   localparam logic [BYTE_W-1:0] END_CHAR_RST    = 8'd3;

   // frames handed from front to back; one per payload bank
   localparam int QUEUE_DEPTH = 2;
   localparam int QCOUNT_W    = 2;

   typedef struct packed {
      logic [LEN_W-1:0]  max_length;
      logic [BYTE_W-1:0] start_char;
      logic [BYTE_W-1:0] escape_char;
      logic [BYTE_W-1:0] end_char;
   } erx_cfg_type;

   // accepted frame waiting for emission
   typedef struct packed {
      logic [TYPE_W-1:0] msg_type;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  count;
      logic              bank;
   } erx_cmd_type;

endpackage

// ===== src/erx_intf.sv =====
// request, response and csr channel interfaces

interface erx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface erx_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] msg_type;
   logic [6:0]  msg_length;
   logic [5:0]  byte_index;
   logic [7:0]  payload_byte;
   logic        has_payload;
   logic        last;
   modport source (output valid, output msg_type, output msg_length, output byte_index,
                   output payload_byte, output has_payload, output last, input ready);
   modport sink (input valid, input msg_type, input msg_length, input byte_index,
                 input payload_byte, input has_payload, input last, output ready);
endinterface

interface erx_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/erx_ram.sv =====
// generic single write, single read ram with registered read data
module erx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/erx_front.sv =====
// front end: byte classification, header parsing, payload capture, checksum
module erx_front #(
   parameter int MAX_PAYLOAD = 64,
   parameter int IDX_W       = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            rx_byte,
   input  erx_pkg::erx_cfg_type  cfg,
   output logic                  wr_en,
   output logic [IDX_W:0]        wr_addr,
   output logic [7:0]            wr_data,
   output logic                  commit,
   output erx_pkg::erx_cmd_type  commit_cmd
);
   import erx_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_TYPEHI = 7'b0000010,
      PH_TYPELO = 7'b0000100,
      PH_LENHI  = 7'b0001000,
      PH_LENLO  = 7'b0010000,
      PH_CHK    = 7'b0100000,
      PH_DATA   = 7'b1000000
   } erx_phase_type;

   erx_phase_type     phase_ff, phase_in;
   logic              esc_ff, esc_in;
   logic              known_ff, known_in;
   logic              bank_ff, bank_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] pxor_ff, pxor_in;

   logic [LEN_W-1:0]  eff_max;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] frame_sum;
   logic              is_start;
   logic              is_escape;
   logic              is_end;

   // byte classification, start first, then escape, then end
   assign is_start  = (rx_byte == cfg.start_char);
   assign is_escape = !is_start && (rx_byte == cfg.escape_char);
   assign is_end    = !is_start && !is_escape && (rx_byte == cfg.end_char);
   assign data_byte = esc_ff ? (rx_byte ^ ESC_MASK) : rx_byte;
   assign eff_max   = (cfg.max_length < MAX_LEN) ? cfg.max_length : MAX_LEN;
   assign frame_sum = type_ff[15:8] ^ type_ff[7:0] ^ {1'b0, len_ff} ^ pxor_ff;

   // next state of the parser
   always_comb begin
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      known_in  = known_ff;
      bank_in   = bank_ff;
      type_in   = type_ff;
      len_hi_in = len_hi_ff;
      len_in    = len_ff;
      chk_in    = chk_ff;
      count_in  = count_ff;
      pxor_in   = pxor_ff;
      wr_en     = 1'b0;
      commit    = 1'b0;
      if (byte_valid) begin
         priority if (is_start) begin
            count_in = '0;
            esc_in   = 1'b0;
            known_in = 1'b0;
            chk_in   = '0;
            pxor_in  = '0;
            phase_in = PH_TYPEHI;
         end else if (is_escape) begin
            esc_in = 1'b1;
         end else if (is_end) begin
            priority if (!known_ff) begin
               phase_in = PH_IDLE;
            end else if (len_ff > eff_max) begin
               phase_in = PH_IDLE;
               known_in = 1'b0;
            end else if (frame_sum == chk_ff) begin
               phase_in = PH_IDLE;
               known_in = 1'b0;
               commit   = 1'b1;
               bank_in  = !bank_ff;
            end else begin
               // bad checksum: the frame stays open as it is
               phase_in = phase_ff;
            end
         end else begin
            esc_in = 1'b0;
            unique case (phase_ff)
               PH_TYPEHI: begin
                  type_in  = {data_byte, 8'h00};
                  phase_in = PH_TYPELO;
               end
               PH_TYPELO: begin
                  type_in  = {type_ff[15:8], data_byte};
                  phase_in = PH_LENHI;
               end
               PH_LENHI: begin
                  len_hi_in = data_byte;
                  phase_in  = PH_LENLO;
               end
               PH_LENLO: begin
                  if ((len_hi_ff != '0) || (data_byte > {1'b0, eff_max})) begin
                     phase_in = PH_IDLE;
                  end else begin
                     len_in   = data_byte[LEN_W-1:0];
                     known_in = 1'b1;
                     phase_in = PH_CHK;
                  end
               end
               PH_CHK: begin
                  chk_in   = data_byte;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if ((count_ff < len_ff) && (count_ff < MAX_LEN)) begin
                     wr_en    = 1'b1;
                     pxor_in  = pxor_ff ^ data_byte;
                     count_in = count_ff + LEN_W'(1);
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // payload store write into the bank of the frame being received
   assign wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign wr_data = data_byte;

   // frame handed to the back end
   assign commit_cmd.msg_type = type_ff;
   assign commit_cmd.length   = len_ff;
   assign commit_cmd.count    = count_ff;
   assign commit_cmd.bank     = bank_ff;

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         esc_ff    <= 1'b0;
         known_ff  <= 1'b0;
         bank_ff   <= 1'b0;
         type_ff   <= '0;
         len_hi_ff <= '0;
         len_ff    <= '0;
         chk_ff    <= '0;
         count_ff  <= '0;
         pxor_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         known_ff  <= known_in;
         bank_ff   <= bank_in;
         type_ff   <= type_in;
         len_hi_ff <= len_hi_in;
         len_ff    <= len_in;
         chk_ff    <= chk_in;
         count_ff  <= count_in;
         pxor_ff   <= pxor_in;
      end
   end

   // an accepted frame leaves the parser idle without a length
   assert property (@(posedge clock) disable iff (reset)
      commit |=> (phase_ff == PH_IDLE) && !known_ff)
      else $error("parser not idle after frame commit");

   // every commit moves reception to the other bank
   assert property (@(posedge clock) disable iff (reset)
      commit |=> (bank_ff != $past(bank_ff)))
      else $error("payload bank not switched on commit");

   // payload writes stay inside the declared length
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> known_ff && (count_ff < len_ff))
      else $error("payload write beyond declared length");

endmodule

// ===== src/erx_queue.sv =====
// two entry queue of accepted frames between front and back end
module erx_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  erx_pkg::erx_cmd_type              push_cmd,
   input  logic                              pop,
   output logic                              head_valid,
   output erx_pkg::erx_cmd_type              head_cmd,
   output logic [erx_pkg::QCOUNT_W-1:0]      count
);
   import erx_pkg::*;

   erx_cmd_type         entry_ff [QUEUE_DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== src/erx_back.sv =====
// back end: reads a committed frame from the payload store and emits its run
module erx_back #(
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  erx_pkg::erx_cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rd_en,
   output logic [IDX_W:0]       rd_addr,
   input  logic [7:0]           rd_data,
   output logic                 busy,
   erx_rsp_if.source            rsp
);
   import erx_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_LOAD = 3'b100
   } erx_back_state_type;

   erx_back_state_type state_ff, state_in;
   erx_cmd_type        cmd_ff, cmd_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]  rsp_type_ff;
   logic [LEN_W-1:0]   rsp_length_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic               rsp_has_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               load;
   logic               item_last;
   logic               has_payload;
   logic [BYTE_W-1:0]  item_byte;

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign has_payload = (cmd_ff.length != '0);
   assign item_last   = !has_payload || ((idx_ff + LEN_W'(1)) == cmd_ff.length);
   // positions never received since the start read as zero
   assign item_byte   = (has_payload && (idx_ff < cmd_ff.count)) ? rd_data : '0;
   assign rd_addr     = {cmd_ff.bank, idx_ff[IDX_W-1:0]};
   assign busy        = (state_ff != B_IDLE);

   // emission sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               idx_in   = '0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_LOAD;
         end
         B_LOAD: begin
            if (out_free) begin
               load = 1'b1;
               if (item_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // frame descriptor and output register
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (load) begin
         rsp_type_ff   <= cmd_ff.msg_type;
         rsp_length_ff <= cmd_ff.length;
         rsp_index_ff  <= idx_ff[INDEX_W-1:0];
         rsp_byte_ff   <= item_byte;
         rsp_has_ff    <= has_payload;
         rsp_last_ff   <= item_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.msg_type     = rsp_type_ff;
   assign rsp.msg_length   = rsp_length_ff;
   assign rsp.byte_index   = rsp_index_ff;
   assign rsp.payload_byte = rsp_byte_ff;
   assign rsp.has_payload  = rsp_has_ff;
   assign rsp.last         = rsp_last_ff;

   // the final item of a run frees the payload bank
   assert property (@(posedge clock) disable iff (reset)
      load && item_last |=> !busy)
      else $error("back end busy after final item");

   // a run starts at position zero
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (idx_ff == '0) && (state_ff == B_READ))
      else $error("run did not start at position zero");

   // items stay inside the frame length
   assert property (@(posedge clock) disable iff (reset)
      load |-> (idx_ff < cmd_ff.length) || !has_payload)
      else $error("item position beyond frame length");

endmodule

// ===== src/escaped_frame_receiver.sv =====
// top level of the escaped serial frame receiver
// path: a frame is queued until the emitter is idle; each result is a ram read, then a load into the output register
// throughput: one input byte per cycle while requests are not stalled; the next read of a run waits for the load
// requests stall while two accepted frames (one per payload bank) are queued or being emitted
// reset: synchronous, clears parser, queue, emitter and restores the csr reset values
// the payload store needs no clearing pass: only positions written since the start are read
module escaped_frame_receiver #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic      clock,
   input  logic      reset,
   erx_req_if.sink   req,
   erx_rsp_if.source rsp,
   erx_csr_if.sink   csr
);
   import erx_pkg::*;

   localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int RAM_DEPTH = 2 << IDX_W;

   erx_cfg_type         cfg_ff, cfg_in;
   logic                byte_valid;
   logic                wr_en;
   logic [IDX_W:0]      wr_addr;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [IDX_W:0]      rd_addr;
   logic [7:0]          rd_data;
   logic                commit;
   erx_cmd_type         commit_cmd;
   logic                q_pop;
   logic                q_valid;
   erx_cmd_type         q_cmd;
   logic [QCOUNT_W-1:0] q_count;
   logic                busy;
   logic [QCOUNT_W-1:0] outstanding;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_MAX_LENGTH:  cfg_in.max_length  = csr.data[LEN_W-1:0];
            CSR_START_CHAR:  cfg_in.start_char  = csr.data;
            CSR_ESCAPE_CHAR: cfg_in.escape_char = csr.data;
            CSR_END_CHAR:    cfg_in.end_char    = csr.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length  <= MAX_LENGTH_RST;
         cfg_ff.start_char  <= START_CHAR_RST;
         cfg_ff.escape_char <= ESCAPE_CHAR_RST;
         cfg_ff.end_char    <= END_CHAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr.ready = 1'b1;

   // one payload bank per outstanding frame
   assign outstanding = q_count + QCOUNT_W'(busy);
   assign req.ready   = (outstanding < QCOUNT_W'(QUEUE_DEPTH));
   assign byte_valid  = req.valid && req.ready;

   erx_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req.rx_byte),
      .cfg        (cfg_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .commit     (commit),
      .commit_cmd (commit_cmd)
   );

   erx_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   erx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (commit),
      .push_cmd   (commit_cmd),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd),
      .count      (q_count)
   );

   erx_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (busy),
      .rsp     (rsp)
   );

endmodule
